// ===== rtl/vrra_pkg.sv =====
`timescale 1ns / 1ps

package vrra_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 65536;
    localparam int unsigned HEADER_BYTES     = 5;
    localparam int unsigned PTR_W            = 17;
    localparam int unsigned OFS_W            = 16;

    localparam logic [PTR_W-1:0] MAX_BYTES_P = PTR_W'(MAX_BUFFER_BYTES);
    localparam logic [PTR_W-1:0] HEADER_P    = PTR_W'(HEADER_BYTES);
    localparam logic [PTR_W-1:0] MIN_BYTES_P = PTR_W'(HEADER_BYTES + 1);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [OFS_W-1:0] ofs_t;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_CONSUME = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        ptr_t wp;
        ptr_t rp;
        logic wrapped;
        logic mark_vld;
        ptr_t mark_pos;
    } ring_state_t;

    typedef struct packed {
        status_t status;
        ofs_t    offset;
        logic    mark_placed;
        ofs_t    mark_offset;
        ptr_t    mark_length;
    } result_t;

endpackage

// ===== rtl/vrra_core.sv =====
`timescale 1ns / 1ps

module vrra_core
(
    input  vrra_pkg::ring_state_t cur,
    input  vrra_pkg::ptr_t        buf_bytes,
    input  vrra_pkg::cmd_t        cmd,
    input  vrra_pkg::ptr_t        size,
    output vrra_pkg::ring_state_t nxt,
    output vrra_pkg::result_t     res
);

    // A position is in the short tail when at most a header fits between it and the end.
    function automatic logic in_short_tail(input vrra_pkg::ptr_t pos, input vrra_pkg::ptr_t bs);
        vrra_pkg::ptr_t left;
        begin
            left = bs - pos;
            in_short_tail = (pos >= bs) || (left <= vrra_pkg::HEADER_P);
        end
    endfunction

    // Allocate path
    logic           wrap_w;
    vrra_pkg::ptr_t w_a;
    logic           wrapped_a;
    vrra_pkg::ptr_t tail_left;
    logic           full_a;
    logic           fit_tail;
    logic           fit_head;
    logic           fit_gap;
    logic           placed;
    logic           put_marker;
    vrra_pkg::ptr_t pos;
    vrra_pkg::ptr_t gap;

    // Reader path
    logic           empty0;
    logic           skip;
    logic           empty_r;
    vrra_pkg::ptr_t r_s;
    logic           wrapped_s;
    logic           mark_vld_s;
    vrra_pkg::ptr_t limit;
    vrra_pkg::ptr_t room;
    vrra_pkg::ptr_t r_adv;

    always_comb
    begin
        wrap_w    = !cur.wrapped && in_short_tail(cur.wp, buf_bytes);
        w_a       = wrap_w ? '0 : cur.wp;
        wrapped_a = cur.wrapped || wrap_w;
        full_a    = wrapped_a && (w_a == cur.rp);
        tail_left = buf_bytes - w_a;
        gap       = cur.rp - w_a;
        fit_tail  = tail_left >= size;
        fit_head  = cur.rp >= size;
        fit_gap   = gap >= size;
        put_marker = 1'b0;
        placed     = 1'b0;
        pos        = w_a;
        if (!full_a)
        begin
            if (w_a >= cur.rp)
            begin
                if (fit_tail)
                begin
                    placed = 1'b1;
                end
                else if (fit_head)
                begin
                    placed     = 1'b1;
                    put_marker = 1'b1;
                    pos        = '0;
                end
            end
            else if (fit_gap)
            begin
                placed = 1'b1;
            end
        end
    end

    // A reader wrap lands on offset zero, which never sits in a short tail
    // (capacity exceeds the header), so at most one skip can happen.
    always_comb
    begin
        empty0     = !cur.wrapped && (cur.rp == cur.wp);
        skip       = !empty0 && (in_short_tail(cur.rp, buf_bytes) ||
                     (cur.mark_vld && (cur.rp == cur.mark_pos)));
        r_s        = skip ? '0 : cur.rp;
        wrapped_s  = skip ? 1'b0 : cur.wrapped;
        mark_vld_s = skip ? 1'b0 : cur.mark_vld;
        empty_r    = skip ? (cur.wp == '0) : empty0;
        if (!wrapped_s)
        begin
            limit = cur.wp;
        end
        else if (mark_vld_s)
        begin
            limit = cur.mark_pos;
        end
        else
        begin
            limit = buf_bytes;
        end
        room = limit - r_s;
        if (r_s < limit)
        begin
            r_adv = (room >= size) ? (r_s + size) : limit;
        end
        else
        begin
            r_adv = r_s;
        end
    end

    always_comb
    begin
        nxt = cur;
        res.status      = vrra_pkg::ST_OK;
        res.offset      = cur.rp[vrra_pkg::OFS_W-1:0];
        res.mark_placed = 1'b0;
        res.mark_offset = '0;
        res.mark_length = '0;
        case (cmd)
            vrra_pkg::CMD_ALLOC:
            begin
                nxt.wp      = w_a;
                nxt.wrapped = wrapped_a;
                res.offset  = '0;
                if (placed)
                begin
                    nxt.wp     = pos + size;
                    res.offset = pos[vrra_pkg::OFS_W-1:0];
                end
                else
                begin
                    res.status = vrra_pkg::ST_NO_SPACE;
                end
                if (put_marker)
                begin
                    nxt.mark_vld    = 1'b1;
                    nxt.mark_pos    = w_a;
                    nxt.wrapped     = 1'b1;
                    res.mark_placed = 1'b1;
                    res.mark_offset = w_a[vrra_pkg::OFS_W-1:0];
                    res.mark_length = tail_left;
                end
            end
            vrra_pkg::CMD_PEEK:
            begin
                nxt.rp       = r_s;
                nxt.wrapped  = wrapped_s;
                nxt.mark_vld = mark_vld_s;
                res.status   = empty_r ? vrra_pkg::ST_EMPTY : vrra_pkg::ST_OK;
                res.offset   = r_s[vrra_pkg::OFS_W-1:0];
            end
            vrra_pkg::CMD_CONSUME:
            begin
                nxt.wrapped  = wrapped_s;
                nxt.mark_vld = mark_vld_s;
                if (empty_r)
                begin
                    nxt.rp     = r_s;
                    res.status = vrra_pkg::ST_EMPTY;
                    res.offset = r_s[vrra_pkg::OFS_W-1:0];
                end
                else
                begin
                    nxt.rp     = r_adv;
                    res.offset = r_adv[vrra_pkg::OFS_W-1:0];
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== rtl/variable_record_ring_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Signals                                            Direction
// in        in_valid, in_ready, command, rec_bytes             to block
// out       out_valid, out_ready, status, offset, marker_*     from block
// cfg       cfg_valid, cfg_ready, cfg_data (buffer_size)       to block
//
// A command is registered on acceptance and its result goes to the output
// register; one command is taken per cycle unless the output stalls. The
// pointer registers update at the edge that loads the result, so the
// following command sees them. Reset is asynchronous and clears all pointers
// and sets the capacity to its maximum. A stalled output holds the command
// stage; the input is taken again as soon as it drains.

module variable_record_ring_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [vrra_pkg::PTR_W-1:0]   rec_bytes,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [vrra_pkg::OFS_W-1:0]   offset,
    output logic                         marker_placed,
    output logic [vrra_pkg::OFS_W-1:0]   marker_offset,
    output logic [vrra_pkg::PTR_W-1:0]   marker_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [vrra_pkg::PTR_W-1:0]   cfg_data
);

    logic                  in_valid_reg;
    vrra_pkg::cmd_t        cmd_reg;
    vrra_pkg::ptr_t        size_reg;
    logic                  out_valid_reg;
    vrra_pkg::result_t     res_reg;
    vrra_pkg::result_t     res_next;
    vrra_pkg::ring_state_t state_reg;
    vrra_pkg::ring_state_t state_next;
    vrra_pkg::ptr_t        bs_reg;
    vrra_pkg::ptr_t        bs_sat;
    logic                  advance;
    logic                  cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data < vrra_pkg::MIN_BYTES_P)
        begin
            bs_sat = vrra_pkg::MIN_BYTES_P;
        end
        else if (cfg_data > vrra_pkg::MAX_BYTES_P)
        begin
            bs_sat = vrra_pkg::MAX_BYTES_P;
        end
        else
        begin
            bs_sat = cfg_data;
        end
    end

    vrra_core u_core
    (
        .cur       (state_reg),
        .buf_bytes (bs_reg),
        .cmd       (cmd_reg),
        .size      (size_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            bs_reg        <= vrra_pkg::MAX_BYTES_P;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                bs_reg    <= bs_sat;
                state_reg <= '0;
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= vrra_pkg::cmd_t'(command);
            size_reg <= rec_bytes;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign offset        = res_reg.offset;
    assign marker_placed = res_reg.mark_placed;
    assign marker_offset = res_reg.mark_offset;
    assign marker_length = res_reg.mark_length;

endmodule
